### src/swtq_pkg.sv
`default_nettype none
package swtq_pkg;

    localparam int TICK_W     = 63;
    localparam int ID_FIELD_W = 8;
    localparam int ID_MAX_W   = 16;

    localparam int DEPTH_DEF    = 16;
    localparam int ID_WIDTH_DEF = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    typedef struct packed {
        logic                  operation;
        logic [ID_FIELD_W-1:0] waiter_id;
        logic [TICK_W-1:0]     wake_tick;
        logic [TICK_W-1:0]     now_tick;
    } t_req;

    typedef struct packed {
        logic [ID_FIELD_W-1:0] released_id;
        logic                  released_valid;
        logic                  insert_rejected;
        logic                  last_result;
    } t_rsp;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // sorted insert of the new entry
        logic shl;   // drop head, everything moves one toward the head
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } t_state;

endpackage
`default_nettype wire

### src/sorted_wakeup_timer_queue_top.sv
`default_nettype none
// Insert: response registered at the edge that takes the request; one insert per cycle
//   while each response is taken. Check: first response registered in the cycle after the
//   request, then one released waiter per cycle from the head cell while each is taken,
//   or a single empty response when nothing is due. Requests wait until the check is done.
// No request is taken while a registered response waits; reset empties queue and response.
module sorted_wakeup_timer_queue_top #(
    parameter int DEPTH    = swtq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = swtq_pkg::ID_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire swtq_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_ready,
    output swtq_pkg::t_rsp      o_rsp
);
    import swtq_pkg::*;

    t_state            r_state, n_state;
    logic [TICK_W-1:0] r_now, n_now;
    logic              r_out_vld, n_out_vld;
    t_rsp              r_out, n_out;

    t_cell_ctl         w_ctl;
    logic              w_vld  [DEPTH];
    logic [TICK_W-1:0] w_tick [DEPTH];
    logic [ID_WIDTH-1:0] w_id [DEPTH];
    logic              w_le   [DEPTH];
    logic              w_due  [DEPTH];

    logic [ID_MAX_W-1:0] w_in_id_ext;
    logic [ID_WIDTH-1:0] w_new_id;
    logic [ID_MAX_W-1:0] w_head_id_ext;

    logic w_acc, w_slot_free, w_full, w_is_ins, w_emit_chk;

    assign w_in_id_ext   = ID_MAX_W'(i_req.waiter_id);
    assign w_new_id      = w_in_id_ext[ID_WIDTH-1:0];
    assign w_head_id_ext = ID_MAX_W'(w_id[0]);

    assign w_full      = w_vld[DEPTH-1];
    assign w_slot_free = !r_out_vld || i_rsp_ready;
    assign o_req_ready = (r_state == ST_IDLE) && w_slot_free;
    assign w_acc       = i_req_valid && o_req_ready;
    assign w_is_ins    = w_acc && (i_req.operation == OP_INSERT);
    assign w_emit_chk  = (r_state == ST_CHECK) && w_slot_free;

    assign w_ctl.ins = w_is_ins && !w_full;
    assign w_ctl.shl = w_emit_chk && w_due[0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                w_pv, w_ple, w_nv;
        logic [TICK_W-1:0]   w_pt, w_nt;
        logic [ID_WIDTH-1:0] w_pi, w_ni;

        if (g == 0) begin : g_head
            assign w_pv  = 1'b0;
            assign w_pt  = '0;
            assign w_pi  = '0;
            assign w_ple = 1'b0;
        end else begin : g_body
            assign w_pv  = w_vld[g-1];
            assign w_pt  = w_tick[g-1];
            assign w_pi  = w_id[g-1];
            assign w_ple = w_le[g-1];
        end

        if (g == DEPTH-1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_nt = '0;
            assign w_ni = '0;
        end else begin : g_inner
            assign w_nv = w_vld[g+1];
            assign w_nt = w_tick[g+1];
            assign w_ni = w_id[g+1];
        end

        swtq_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_wake      (i_req.wake_tick),
            .i_new_id    (w_new_id),
            .i_now       (r_now),
            .i_prev_vld  (w_pv),
            .i_prev_tick (w_pt),
            .i_prev_id   (w_pi),
            .i_prev_le   (w_ple),
            .i_next_vld  (w_nv),
            .i_next_tick (w_nt),
            .i_next_id   (w_ni),
            .o_vld       (w_vld[g]),
            .o_tick      (w_tick[g]),
            .o_id        (w_id[g]),
            .o_le        (w_le[g]),
            .o_due       (w_due[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_now     = r_now;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_rsp_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_req.operation == OP_INSERT) begin
                        n_out_vld             = 1'b1;
                        n_out.released_id     = '0;
                        n_out.released_valid  = 1'b0;
                        n_out.insert_rejected = w_full;
                        n_out.last_result     = 1'b1;
                    end else begin
                        n_now   = i_req.now_tick;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (w_slot_free) begin
                    n_out_vld             = 1'b1;
                    n_out.insert_rejected = 1'b0;
                    if (w_due[0]) begin
                        n_out.released_id    = w_head_id_ext[ID_FIELD_W-1:0];
                        n_out.released_valid = 1'b1;
                        // last when the next cell is not also due
                        n_out.last_result    = !w_due[1];
                        if (!w_due[1]) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_out.released_id    = '0;
                        n_out.released_valid = 1'b0;
                        n_out.last_result    = 1'b1;
                        n_state              = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now <= n_now;
        r_out <= n_out;
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

endmodule
`default_nettype wire

### src/swtq_cell.sv
`default_nettype none
module swtq_cell #(
    parameter int ID_WIDTH = swtq_pkg::ID_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire swtq_pkg::t_cell_ctl         i_ctl,
    input  wire logic [swtq_pkg::TICK_W-1:0] i_wake,
    input  wire logic [ID_WIDTH-1:0]         i_new_id,
    input  wire logic [swtq_pkg::TICK_W-1:0] i_now,
    // neighbor toward the head
    input  wire logic                        i_prev_vld,
    input  wire logic [swtq_pkg::TICK_W-1:0] i_prev_tick,
    input  wire logic [ID_WIDTH-1:0]         i_prev_id,
    input  wire logic                        i_prev_le,
    // neighbor toward the tail
    input  wire logic                        i_next_vld,
    input  wire logic [swtq_pkg::TICK_W-1:0] i_next_tick,
    input  wire logic [ID_WIDTH-1:0]         i_next_id,
    output logic                             o_vld,
    output logic [swtq_pkg::TICK_W-1:0]      o_tick,
    output logic [ID_WIDTH-1:0]              o_id,
    output logic                             o_le,
    output logic                             o_due
);
    import swtq_pkg::*;

    logic                r_vld, n_vld;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [ID_WIDTH-1:0] r_id, n_id;

    // new entry belongs at or before this slot
    assign o_le  = !r_vld || (i_wake <= r_tick);
    assign o_due = r_vld && (r_tick <= i_now);

    always_comb begin
        n_vld  = r_vld;
        n_tick = r_tick;
        n_id   = r_id;
        if (i_ctl.ins) begin
            if (i_prev_le) begin
                n_vld  = i_prev_vld;
                n_tick = i_prev_tick;
                n_id   = i_prev_id;
            end else if (o_le) begin
                n_vld  = 1'b1;
                n_tick = i_wake;
                n_id   = i_new_id;
            end
        end else if (i_ctl.shl) begin
            n_vld  = i_next_vld;
            n_tick = i_next_tick;
            n_id   = i_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick <= n_tick;
        r_id   <= n_id;
    end

    assign o_vld  = r_vld;
    assign o_tick = r_tick;
    assign o_id   = r_id;

endmodule
`default_nettype wire
